### rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared sizes, codes and controller/datapath handshake types for the page
// frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Map geometry
  localparam int NUM_FRAMES  = 32768;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int MAP_W       = 64;
  localparam int BIT_W       = $clog2(MAP_W);
  localparam int NUM_WORDS   = (NUM_FRAMES + MAP_W - 1) / MAP_W;
  localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GIDX_W      = WADDR_W + BIT_W;
  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = MAP_W / CHUNK_W;
  localparam int CHK_W       = $clog2(NUM_CHUNKS);
  localparam int CHUNK_BIT_W = $clog2(CHUNK_W);

  // Field widths
  localparam int ACT_W      = 2;
  localparam int COUNT_W    = 16;
  localparam int ADDR_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;

  // Response codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END  = 1'b1;

  // Result preset selected by the controller
  typedef enum logic [1:0] {
    RES_NONE,
    RES_BASE,
    RES_NOSPACE,
    RES_BADADDR
  } res_op_t;

  typedef struct packed {
    logic    load_req;
    logic    clr_step;
    logic    scan_start;
    logic    scan_eval;
    logic    scan_chunk;
    logic    scan_adv;
    logic    free_chk;
    logic    rng_init_alloc;
    logic    rng_init_free;
    logic    rng_write;
    logic    res_set;
    res_op_t res_op;
    logic    out_load;
  } pfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_free;
    logic is_peek;
    logic cnt_zero;
    logic cnt_big;
    logic ev_hit;
    logic ev_mixed;
    logic ch_hit;
    logic ch_last;
    logic last_word;
    logic chk_bad;
    logic rng_empty;
    logic rng_last;
    logic out_busy;
  } pfa_sts_t;

endpackage

### rtl/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [COUNT_W-1:0] page_count;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, output action, output page_count, output address,
                  input ready);
  modport sink   (input valid, input action, input page_count, input address,
                  output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   frame_address;

  modport source (output valid, output status, output frame_address, input ready);
  modport sink   (input valid, input status, input frame_address, output ready);
endinterface

### rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for the allocator: clearing pass, request decode, first-fit scan,
// range mark/clear and result hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfa_sts_t sts,
  output pfa_cmd_t cmd
);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_CLEAR      = 4'd0;
  localparam logic [SW-1:0] S_IDLE       = 4'd1;
  localparam logic [SW-1:0] S_DECODE     = 4'd2;
  localparam logic [SW-1:0] S_SCAN_EVAL  = 4'd3;
  localparam logic [SW-1:0] S_SCAN_CHUNK = 4'd4;
  localparam logic [SW-1:0] S_MARK_INIT  = 4'd5;
  localparam logic [SW-1:0] S_FREE_CHK   = 4'd6;
  localparam logic [SW-1:0] S_FREE_DEC   = 4'd7;
  localparam logic [SW-1:0] S_RNG_WR     = 4'd8;
  localparam logic [SW-1:0] S_DONE       = 4'd9;

  logic [SW-1:0] state_r;
  logic [SW-1:0] state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_alloc && sts.cnt_zero) begin
          cmd.res_set = 1'b1;
          cmd.res_op  = RES_BASE;
          state_nxt   = S_DONE;
        end else if (sts.is_alloc && sts.cnt_big) begin
          cmd.res_set = 1'b1;
          cmd.res_op  = RES_NOSPACE;
          state_nxt   = S_DONE;
        end else if (sts.is_alloc || sts.is_peek) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_EVAL;
        end else if (sts.is_free) begin
          state_nxt = S_FREE_CHK;
        end else begin
          cmd.res_set = 1'b1;
          cmd.res_op  = RES_NONE;
          state_nxt   = S_DONE;
        end
      end
      S_SCAN_EVAL: begin
        cmd.scan_eval = 1'b1;
        priority if (sts.ev_hit) begin
          state_nxt = sts.is_alloc ? S_MARK_INIT : S_DONE;
        end else if (sts.ev_mixed) begin
          state_nxt = S_SCAN_CHUNK;
        end else if (sts.last_word) begin
          cmd.res_set = 1'b1;
          cmd.res_op  = RES_NOSPACE;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_SCAN_CHUNK: begin
        cmd.scan_chunk = 1'b1;
        priority if (sts.ch_hit) begin
          state_nxt = sts.is_alloc ? S_MARK_INIT : S_DONE;
        end else if (sts.ch_last && sts.last_word) begin
          cmd.res_set = 1'b1;
          cmd.res_op  = RES_NOSPACE;
          state_nxt   = S_DONE;
        end else if (sts.ch_last) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN_EVAL;
        end else begin
          state_nxt = S_SCAN_CHUNK;
        end
      end
      S_MARK_INIT: begin
        cmd.rng_init_alloc = 1'b1;
        state_nxt          = S_RNG_WR;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_FREE_DEC;
      end
      S_FREE_DEC: begin
        cmd.res_set = 1'b1;
        priority if (sts.chk_bad) begin
          cmd.res_op = RES_BADADDR;
          state_nxt  = S_DONE;
        end else if (sts.rng_empty) begin
          cmd.res_op = RES_NONE;
          state_nxt  = S_DONE;
        end else begin
          cmd.res_op        = RES_NONE;
          cmd.rng_init_free = 1'b1;
          state_nxt         = S_RNG_WR;
        end
      end
      S_RNG_WR: begin
        cmd.rng_write = 1'b1;
        if (sts.rng_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

### rtl/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// Allocator datapath: configuration registers, used/free map RAM, run
// tracking for the first-fit scan, range masking and the response register.
// ----------------------------------------------------------------------------
module pfa_dp import pfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfa_cmd_t              cmd,
  output pfa_sts_t              sts,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [COUNT_W-1:0]    in_page_count,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ADDR_W-1:0]     out_frame_address
);

  // Configuration
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] end_r;

  // Request
  logic [ACT_W-1:0]   action_r;
  logic [COUNT_W-1:0] count_r;
  logic [ADDR_W-1:0]  addr_r;

  // Scan and range state
  logic [WADDR_W-1:0] word_r;
  logic [CHK_W-1:0]   chunk_r;
  logic [COUNT_W-1:0] run_r;
  logic [GIDX_W-1:0]  start_r;
  logic [GIDX_W-1:0]  lo_r;
  logic [GIDX_W-1:0]  hi_r;
  logic               rng_set_r;
  logic               bad_r;
  logic [ADDR_W-1:0]  diff_r;

  // Pending result
  logic [STATUS_W-1:0] rslt_status_r;
  logic [GIDX_W-1:0]   rslt_idx_r;
  logic                rslt_has_addr_r;

  // Response register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  // RAM ports
  logic               ram_wr_en;
  logic [MAP_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [WADDR_W-1:0] ram_rd_addr;
  logic [MAP_W-1:0]   ram_rd_data;

  logic [MAP_W-1:0]     word_d;
  logic [MAP_W-1:0]     pad;
  logic [MAP_W-1:0]     rng_mask;
  logic [GIDX_W-1:0]    word_base;
  logic                 all_free;
  logic                 all_used;
  logic [COUNT_W:0]     run_sum;
  logic [GIDX_W-1:0]    fast_start;
  logic [COUNT_W-1:0]   ch_run;
  logic [GIDX_W-1:0]    ch_start;
  logic [GIDX_W-1:0]    ch_hstart;
  logic                 ch_hit;
  logic [CHUNK_W-1:0]   ch_bits;
  logic [GIDX_W-1:0]    lo_nxt;
  logic [GIDX_W-1:0]    hi_nxt;
  logic [31:0]          hi_sum;
  logic [GIDX_W-1:0]    free_idx;
  logic [WADDR_W-1:0]   word_inc;

  pfa_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (word_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign word_inc  = word_r + 1'b1;
  assign word_base = {word_r, {BIT_W{1'b0}}};
  assign free_idx  = diff_r[PAGE_SHIFT +: GIDX_W];

  // Mark frames past the map end as used, build the range mask
  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      pad[j]      = 32'({word_r, BIT_W'(j)}) >= 32'(NUM_FRAMES);
      rng_mask[j] = ({word_r, BIT_W'(j)} >= lo_r) && ({word_r, BIT_W'(j)} <= hi_r);
    end
  end

  // Whole-word view of the fetched map word
  assign word_d     = ram_rd_data | pad;
  assign all_free   = (word_d == '0);
  assign all_used   = (word_d == '1);
  assign run_sum    = {1'b0, run_r} + (COUNT_W + 1)'(MAP_W);
  assign fast_start = (run_r == '0) ? word_base : start_r;

  // Bit-by-bit run tracking over one chunk
  assign ch_bits = word_d[chunk_r * CHUNK_W +: CHUNK_W];

  always_comb begin
    logic [GIDX_W-1:0] pos;
    ch_run    = run_r;
    ch_start  = start_r;
    ch_hit    = 1'b0;
    ch_hstart = start_r;
    for (int j = 0; j < CHUNK_W; j++) begin
      pos = {word_r, chunk_r, CHUNK_BIT_W'(j)};
      if (!ch_hit) begin
        if (!ch_bits[j]) begin
          if (ch_run == '0) begin
            ch_start = pos;
          end
          ch_run = ch_run + 1'b1;
          if (ch_run == count_r) begin
            ch_hit    = 1'b1;
            ch_hstart = ch_start;
          end
        end else begin
          ch_run = '0;
        end
      end
    end
  end

  // Range bounds for mark or clear
  always_comb begin
    if (cmd.rng_init_alloc) begin
      lo_nxt = rslt_idx_r;
      hi_sum = 32'(rslt_idx_r) + 32'(count_r) - 32'd1;
      hi_nxt = hi_sum[GIDX_W-1:0];
    end else begin
      lo_nxt = free_idx;
      hi_sum = 32'(free_idx) + 32'(count_r) - 32'd1;
      hi_nxt = (hi_sum > 32'(NUM_FRAMES - 1)) ? GIDX_W'(NUM_FRAMES - 1)
                                              : hi_sum[GIDX_W-1:0];
    end
  end

  // Status to the controller
  always_comb begin
    sts.clr_last  = (word_r == WADDR_W'(NUM_WORDS - 1));
    sts.is_alloc  = (action_r == ACT_ALLOC);
    sts.is_free   = (action_r == ACT_FREE);
    sts.is_peek   = (action_r == ACT_PEEK);
    sts.cnt_zero  = (count_r == '0);
    sts.cnt_big   = (32'(count_r) > 32'(NUM_FRAMES));
    sts.ev_hit    = all_free && (run_sum >= {1'b0, count_r});
    sts.ev_mixed  = !all_free && !all_used;
    sts.ch_hit    = ch_hit;
    sts.ch_last   = (chunk_r == CHK_W'(NUM_CHUNKS - 1));
    sts.last_word = (word_r == WADDR_W'(NUM_WORDS - 1));
    sts.chk_bad   = bad_r;
    sts.rng_empty = (count_r == '0) || ((diff_r >> PAGE_SHIFT) >= 64'(NUM_FRAMES));
    sts.rng_last  = (word_r == hi_r[GIDX_W-1:BIT_W]);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // Map RAM access
  always_comb begin
    ram_wr_en   = cmd.clr_step || cmd.rng_write;
    ram_wr_data = cmd.clr_step ? '0
                : (rng_set_r ? (ram_rd_data | rng_mask) : (ram_rd_data & ~rng_mask));
    ram_rd_en   = cmd.scan_start || cmd.scan_adv || cmd.rng_init_alloc ||
                  cmd.rng_init_free || (cmd.rng_write && !sts.rng_last);
    priority if (cmd.scan_start) begin
      ram_rd_addr = '0;
    end else if (cmd.rng_init_alloc || cmd.rng_init_free) begin
      ram_rd_addr = lo_nxt[GIDX_W-1:BIT_W];
    end else begin
      ram_rd_addr = word_inc;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      end_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE: base_r <= cfg_wr_data;
        CFG_END:  end_r  <= cfg_wr_data;
        default:  base_r <= base_r;
      endcase
    end
  end

  // Request capture and free-address check
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      action_r <= in_action;
      count_r  <= (in_action == ACT_PEEK) ? COUNT_W'(1) : in_page_count;
      addr_r   <= in_address;
    end
    if (cmd.free_chk) begin
      bad_r  <= (addr_r[PAGE_SHIFT-1:0] != '0) || (addr_r < base_r) || (addr_r > end_r);
      diff_r <= addr_r - base_r;
    end
    if (cmd.rng_init_alloc || cmd.rng_init_free) begin
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      rng_set_r <= cmd.rng_init_alloc;
    end
  end

  // Word pointer, chunk pointer and run tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      chunk_r <= '0;
      run_r   <= '0;
      start_r <= '0;
    end else begin
      priority if (cmd.clr_step) begin
        word_r <= sts.clr_last ? '0 : word_inc;
      end else if (cmd.scan_start) begin
        word_r  <= '0;
        chunk_r <= '0;
        run_r   <= '0;
      end else if (cmd.rng_init_alloc || cmd.rng_init_free) begin
        word_r <= lo_nxt[GIDX_W-1:BIT_W];
      end else if (cmd.rng_write && !sts.rng_last) begin
        word_r <= word_inc;
      end else if (cmd.scan_eval) begin
        if (all_used) begin
          run_r <= '0;
        end else if (all_free) begin
          run_r   <= run_sum[COUNT_W-1:0];
          start_r <= fast_start;
        end
        if (cmd.scan_adv) begin
          word_r <= word_inc;
        end
      end else if (cmd.scan_chunk) begin
        run_r   <= ch_run;
        start_r <= ch_start;
        chunk_r <= chunk_r + 1'b1;
        if (cmd.scan_adv) begin
          word_r <= word_inc;
        end
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rslt_status_r   <= ST_OK;
      rslt_has_addr_r <= 1'b0;
      rslt_idx_r      <= '0;
    end else if (cmd.res_set) begin
      unique case (cmd.res_op)
        RES_NONE: begin
          rslt_status_r   <= ST_OK;
          rslt_has_addr_r <= 1'b0;
        end
        RES_BASE: begin
          rslt_status_r   <= ST_OK;
          rslt_has_addr_r <= 1'b1;
          rslt_idx_r      <= '0;
        end
        RES_NOSPACE: begin
          rslt_status_r   <= ST_NOSPACE;
          rslt_has_addr_r <= 1'b0;
        end
        RES_BADADDR: begin
          rslt_status_r   <= ST_BADADDR;
          rslt_has_addr_r <= 1'b0;
        end
        default: begin
          rslt_status_r <= ST_OK;
        end
      endcase
    end else if (cmd.scan_eval && sts.ev_hit) begin
      rslt_status_r   <= ST_OK;
      rslt_has_addr_r <= 1'b1;
      rslt_idx_r      <= fast_start;
    end else if (cmd.scan_chunk && ch_hit) begin
      rslt_status_r   <= ST_OK;
      rslt_has_addr_r <= 1'b1;
      rslt_idx_r      <= ch_hstart;
    end
  end

  // Response register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= rslt_status_r;
      out_addr_r   <= rslt_has_addr_r ? (base_r + (ADDR_W'(rslt_idx_r) << PAGE_SHIFT))
                                      : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_frame_address = out_addr_r;

endmodule

### rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a used/free bitmap held in RAM, 64
// frames per word. Handles allocate, free and peek requests one at a time.
// ----------------------------------------------------------------------------
// Sequence: allocate/peek scan the map a word at a time, stepping through a
//   partly used word chunk by chunk; an allocate then marks its range word
//   by word. Free checks the address and, if good, clears its range by word.
// Requests: one at a time; the next beat is taken in the cycle after the
//   response loads. The scan uses the single map read port.
// Reset: registers clear, then a clearing pass zeroes all 512 map words.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator import pfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pfa_req_if.sink               in_req,
  pfa_rsp_if.source             out_rsp,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;
  logic     in_ready;

  // Sequencer
  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Map, scan and response datapath
  pfa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_req.action),
    .in_page_count     (in_req.page_count),
    .in_address        (in_req.address),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .out_ready         (out_rsp.ready),
    .out_valid         (out_rsp.valid),
    .out_status        (out_rsp.status),
    .out_frame_address (out_rsp.frame_address)
  );

  assign in_req.ready = in_ready;

endmodule

### tb/sv/pfa_frame_checker.sv
// ----------------------------------------------------------------------------
// pfa_frame_checker
// Watches the request, response and register ports of the page frame
// allocator. Every accepted request updates a private copy of the frame map
// and queues the response it must produce. Every response beat is then
// compared, field by field, with the oldest queued response.
// ----------------------------------------------------------------------------
module pfa_frame_checker import pfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pfa_req_if                    req_mon,
  pfa_rsp_if                    rsp_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output int                    error_count,
  output int                    expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
  } frame_rsp_t;

  bit [NUM_FRAMES-1:0] frame_used;
  logic [ADDR_W-1:0]   base_addr_reg;
  logic [ADDR_W-1:0]   end_addr_reg;
  frame_rsp_t          pending_rsp_q[$];

  function automatic logic [ADDR_W-1:0] frame_byte_addr(input int unsigned frame);
    return base_addr_reg + (64'(frame) << PAGE_SHIFT);
  endfunction

  // Lowest run of 'want' free frames; zero length fits at frame 0
  function automatic bit first_fit(input int unsigned want, output int unsigned start);
    int unsigned run_len;
    int unsigned i;
    start   = 0;
    run_len = 0;
    if (want == 0) return 1'b1;
    if (want > NUM_FRAMES) return 1'b0;
    for (i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_used[i]) begin
        run_len++;
        if (run_len == want) begin
          start = i + 1 - want;
          return 1'b1;
        end
      end else begin
        run_len = 0;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the map copy and build the response it owes
  function automatic frame_rsp_t predict_frame_op(input logic [ACT_W-1:0]   act,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic [ADDR_W-1:0]  addr);
    frame_rsp_t       rsp;
    int unsigned      start;
    longint unsigned  first_frame;
    longint unsigned  k;
    rsp.status        = ST_OK;
    rsp.frame_address = '0;
    case (act)
      ACT_ALLOC: begin
        if (first_fit(cnt, start)) begin
          for (k = 0; k < cnt; k++) frame_used[start + k] = 1'b1;
          rsp.frame_address = frame_byte_addr(start);
        end else begin
          rsp.status = ST_NOSPACE;
        end
      end
      ACT_PEEK: begin
        if (first_fit(1, start)) begin
          rsp.frame_address = frame_byte_addr(start);
        end else begin
          rsp.status = ST_NOSPACE;
        end
      end
      ACT_FREE: begin
        if (addr[PAGE_SHIFT-1:0] != '0 || addr < base_addr_reg || addr > end_addr_reg) begin
          rsp.status = ST_BADADDR;
        end else begin
          // clip the run at the last frame of the map
          first_frame = (addr - base_addr_reg) >> PAGE_SHIFT;
          for (k = first_frame; k < first_frame + cnt && k < NUM_FRAMES; k++)
            frame_used[k] = 1'b0;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    frame_rsp_t want;
    if (!rst_n) begin
      frame_used    = '0;
      base_addr_reg = '0;
      end_addr_reg  = '0;
      pending_rsp_q.delete();
    end else begin
      // track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BASE: base_addr_reg = cfg_wr_data;
          CFG_END:  end_addr_reg  = cfg_wr_data;
          default: ;
        endcase
      end

      // queue the response owed by each request beat
      if (req_mon.valid && req_mon.ready)
        pending_rsp_q.push_back(predict_frame_op(req_mon.action, req_mon.page_count,
                                                 req_mon.address));

      // compare each response beat with the oldest expectation
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response beat: status %0d frame_address %h",
                   $time, rsp_mon.status, rsp_mon.frame_address);
          error_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_mon.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp_mon.status);
            error_count++;
          end
          if (rsp_mon.frame_address !== want.frame_address) begin
            $display("%0t: frame_address mismatch: expected %h, actual %h",
                     $time, want.frame_address, rsp_mon.frame_address);
            error_count++;
          end
        end
      end
    end
    expected_left = pending_rsp_q.size();
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus top for the page frame allocator: a directed pass over the corner
// cases, then random request mixes under several base/end register settings
// with random idle bursts on both channels. Checking is done by the
// pfa_frame_checker instance; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;
  localparam int               LIMIT_CYCLES = 20_000_000;
  localparam int               NUM_PHASES   = 7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  pfa_req_if req_ch();
  pfa_rsp_if rsp_ch();

  int          error_count;
  int          expected_left;
  int unsigned req_sent    = 0;
  int unsigned rsp_got     = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_left  = 0;
  logic [ADDR_W-1:0] cur_base = '0;
  logic [ADDR_W-1:0] cur_end  = '0;

  page_frame_bitmap_allocator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch.sink),
    .out_rsp     (rsp_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  pfa_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the response channel in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 15);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Count response beats
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) rsp_got <= rsp_got + 1;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // All driving tasks start and end at a falling edge
  task automatic send_item(input logic [ACT_W-1:0]   act,
                           input logic [COUNT_W-1:0] cnt,
                           input logic [ADDR_W-1:0]  addr);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.page_count <= cnt;
    req_ch.address    <= addr;
    do @(posedge clk); while (!req_ch.ready);
    req_sent++;
    @(negedge clk);
  endtask

  // Hold requests until every response has come back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (rsp_got != req_sent) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0]  reg_idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= reg_idx;
    cfg_wr_data <= value;
    if (reg_idx == CFG_BASE) cur_base = value;
    else cur_end = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count(input bit for_alloc);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) return COUNT_W'($urandom_range(1, 8));
    if (r < 92) return COUNT_W'($urandom_range(9, 80));
    if (r < 95) return '0;
    // large allocations fail at once; large frees sweep the map
    if (r < 99) begin
      if (for_alloc) return COUNT_W'($urandom_range(NUM_FRAMES + 1, 16'hFFFF));
      return COUNT_W'($urandom_range(0, 16'hFFFF));
    end
    return COUNT_W'($urandom_range(100, 600));
  endfunction

  // Mostly well-formed allocate/free/peek traffic, with some broken frees
  task automatic random_item();
    int unsigned       pick;
    int unsigned       idx;
    logic [ADDR_W-1:0] page0;
    logic [ADDR_W-1:0] addr;
    pick  = $urandom_range(0, 99);
    page0 = (cur_base + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);
    idx   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, NUM_FRAMES + 64)
                                         : $urandom_range(0, 400);
    if (pick < 40) begin
      send_item(ACT_ALLOC, pick_count(1'b1), {$urandom, $urandom});
    end else if (pick < 75) begin
      send_item(ACT_FREE, pick_count(1'b0), page0 + (64'(idx) << PAGE_SHIFT));
    end else if (pick < 87) begin
      send_item(ACT_PEEK, COUNT_W'($urandom), {$urandom, $urandom});
    end else if (pick < 90) begin
      send_item(ACT_UNUSED, COUNT_W'($urandom), {$urandom, $urandom});
    end else begin
      case ($urandom_range(0, 3))
        0: addr = {$urandom, $urandom};
        1: addr = page0 + (64'(idx) << PAGE_SHIFT) + 64'($urandom_range(1, PAGE_BYTES - 1));
        2: addr = ((cur_end >> PAGE_SHIFT) + 64'($urandom_range(1, 8))) << PAGE_SHIFT;
        default: addr = page0 - (64'($urandom_range(1, 8)) << PAGE_SHIFT);
      endcase
      send_item(ACT_FREE, pick_count(1'b0), addr);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] phase_base [NUM_PHASES];
    logic [ADDR_W-1:0] phase_end  [NUM_PHASES];
    int unsigned       phase_len  [NUM_PHASES];
    int unsigned       phase_idle [NUM_PHASES];
    int unsigned       p;
    int unsigned       n;

    phase_base = '{64'h0, 64'h0000_1234_5000_0000, 64'hFFFF_FFFF_FFF8_0000,
                   64'h0000_0000_0000_0800, '1, 64'h0, 64'h0000_0000_8000_0000};
    phase_end  = '{'1, 64'h0000_1234_502B_C000, '1,
                   64'h0000_0000_0400_0000, '1, 64'h0, '1};
    phase_len  = '{200, 200, 200, 200, 60, 60, 200};
    phase_idle = '{25, 10, 40, 15, 20, 0, 0};

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wr_data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.action     = '0;
    req_ch.page_count = '0;
    req_ch.address    = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners with the reset register values (base 0, end 0)
    idle_pct = 20;
    send_item(ACT_PEEK, '0, '0);
    send_item(ACT_ALLOC, '0, '1);
    send_item(ACT_ALLOC, 16'd1, '0);
    send_item(ACT_ALLOC, 16'd3, '0);
    send_item(ACT_PEEK, 16'hFFFF, '1);
    send_item(ACT_FREE, 16'd1, 64'h0);
    send_item(ACT_FREE, 16'd1, 64'h1000);
    send_item(ACT_FREE, '0, 64'h0);
    send_item(ACT_ALLOC, 16'hFFFF, '0);
    send_item(ACT_ALLOC, COUNT_W'(NUM_FRAMES + 1), '0);
    send_item(ACT_UNUSED, 16'hA5A5, 64'hDEAD_BEEF_0000_1000);

    // Directed corners over the whole address space: full map, clipping
    drain_responses();
    cfg_write(CFG_BASE, 64'h0);
    cfg_write(CFG_END, '1);
    send_item(ACT_FREE, 16'hFFFF, 64'h0);
    send_item(ACT_ALLOC, COUNT_W'(NUM_FRAMES), '0);
    send_item(ACT_PEEK, '0, '0);
    send_item(ACT_ALLOC, 16'd1, '0);
    send_item(ACT_FREE, 16'd10, 64'(NUM_FRAMES - 2) << PAGE_SHIFT);
    send_item(ACT_FREE, 16'd5, 64'(NUM_FRAMES) << PAGE_SHIFT);
    send_item(ACT_ALLOC, 16'd2, '0);
    send_item(ACT_FREE, 16'd4, 64'h3000);
    send_item(ACT_ALLOC, 16'd3, '0);
    send_item(ACT_PEEK, '0, '0);
    send_item(ACT_FREE, 16'd1, 64'hFFFF_FFFF_FFFF_F000);
    send_item(ACT_FREE, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_FREE, 16'hFFFF, 64'h0);

    // Random phases, one register setting each; the last ones run without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_responses();
      idle_pct = phase_idle[p];
      cfg_write(CFG_BASE, phase_base[p]);
      cfg_write(CFG_END, phase_end[p]);
      send_item(ACT_FREE, 16'hFFFF, (cur_base + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1));
      for (n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(0, 99) == 0) drain_responses();
        random_item();
      end
    end

    drain_responses();
    repeat (16) @(negedge clk);
    if (error_count == 0 && expected_left == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
